### src/assert_macros.svh
// assertion macros used by the rtl unit
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent in the same cycle implies consequent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### src/rscw_pkg.sv
// types and codes for the rtt scaled congestion window unit
// no dependencies
package rscw_pkg;

   localparam logic [1:0] MODE_ACK  = 2'd0;
   localparam logic [1:0] MODE_RTT  = 2'd1;
   localparam logic [1:0] MODE_LOSS = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic        window_limited;
      logic [15:0] acked_count;
      logic [31:0] rtt_sample_us;
      logic [31:0] window_now;
      logic [31:0] window_fraction_now;
      logic [31:0] slow_start_limit;
   } req_type;

   typedef struct packed {
      logic [31:0] window_next;
      logic [31:0] window_fraction_next;
   } rsp_type;

endpackage

### src/rscw_req_if.sv
// request channel carrying one input item
// depends on rscw_pkg
interface rscw_req_if;
   logic             valid;
   logic             ready;
   rscw_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### src/rscw_rsp_if.sv
// response channel carrying one result item
// depends on rscw_pkg
interface rscw_rsp_if;
   logic             valid;
   logic             ready;
   rscw_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### src/rtt_scaled_congestion_window_unit.sv
// Congestion window update scaled by round-trip time. Every item but an ack in
// congestion avoidance is answered from the output register in the cycle after
// acceptance. For such an ack one shared 33-bit subtractor runs a 32-step
// restoring divide (peak / latest), a combinational 32x32 multiply, a 16-step
// square root and a second 32-step divide (root / window) under a small
// sequencer. The unit takes one item at a time; a result waits in an output
// register, and a new item is accepted only when that register is free or read.
// depends on rscw_pkg, rscw_req_if, rscw_rsp_if and assert_macros.svh
`include "assert_macros.svh"

module rtt_scaled_congestion_window_unit (
   input  logic        clock,
   input  logic        reset,
   rscw_req_if.sink    req_chan,
   rscw_rsp_if.source  rsp_chan
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV1 = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_SQRT = 3'd3;
   localparam logic [2:0] ST_DIV2 = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [4:0]  count_ff, count_in;
   logic [31:0] peak_ff, peak_in;
   logic [31:0] latest_ff, latest_in;
   logic [31:0] win_ff, win_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [31:0] q_ff, q_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] divisor_ff, divisor_in;
   logic [31:0] bit_ff, bit_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rscw_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   rscw_pkg::req_type req;
   logic        accept;
   logic [32:0] sub_a, sub_b;
   logic [33:0] sub_diff;
   logic        sub_borrow;
   logic [31:0] product;
   logic [31:0] rtt_inc;
   logic [32:0] ss_sum;
   logic [31:0] cnt_sum;

   assign req    = req_chan.payload;
   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   // shared subtractor: divide step or square-root step
   always_comb begin
      if (state_ff == ST_SQRT) begin
         sub_a = {1'b0, rem_ff};
         sub_b = {1'b0, q_ff + bit_ff};
      end else begin
         sub_a = {rem_ff, q_ff[31]};
         sub_b = {1'b0, divisor_ff};
      end
   end
   assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_borrow = sub_diff[33];

   assign product = q_ff * win_ff;
   assign rtt_inc = (req.rtt_sample_us == 32'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                         : req.rtt_sample_us + 32'd1;
   assign ss_sum  = {1'b0, req.window_now} + {17'd0, req.acked_count};
   assign cnt_sum = cnt_ff + q_ff;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      peak_in        = peak_ff;
      latest_in      = latest_ff;
      win_in         = win_ff;
      cnt_in         = cnt_ff;
      q_in           = q_ff;
      rem_in         = rem_ff;
      divisor_in     = divisor_ff;
      bit_in         = bit_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_payload_in = rsp_payload_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // echo by default, overridden below
               rsp_payload_in.window_next          = req.window_now;
               rsp_payload_in.window_fraction_next = req.window_fraction_now;
               rsp_valid_in = 1'b1;
               case (req.mode)
                  rscw_pkg::MODE_RTT: begin
                     latest_in = rtt_inc;
                     if (rtt_inc > peak_ff || peak_ff == 32'd0) begin
                        peak_in = rtt_inc;
                     end
                  end
                  rscw_pkg::MODE_LOSS: begin
                     peak_in = 32'd0;
                  end
                  rscw_pkg::MODE_ACK: begin
                     if (req.window_limited) begin
                        if (req.window_now < req.slow_start_limit) begin
                           rsp_payload_in.window_next =
                              (ss_sum < {1'b0, req.slow_start_limit}) ? ss_sum[31:0]
                                                                      : req.slow_start_limit;
                        end else if (req.window_now == 32'd0) begin
                           // zero window: no increment, counter clears, window becomes one
                           rsp_payload_in.window_next          = 32'd1;
                           rsp_payload_in.window_fraction_next = 32'd0;
                        end else begin
                           rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
                           win_in       = req.window_now;
                           cnt_in       = req.window_fraction_now;
                           q_in         = peak_ff;
                           rem_in       = 32'd0;
                           divisor_in   = (latest_ff == 32'd0) ? 32'd1 : latest_ff;
                           count_in     = 5'd31;
                           state_in     = ST_DIV1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV1, ST_DIV2: begin
            if (!sub_borrow) begin
               rem_in = sub_diff[31:0];
               q_in   = {q_ff[30:0], 1'b1};
            end else begin
               rem_in = sub_a[31:0];
               q_in   = {q_ff[30:0], 1'b0};
            end
            count_in = count_ff - 5'd1;
            if (count_ff == 5'd0) begin
               state_in = (state_ff == ST_DIV1) ? ST_MUL : ST_DONE;
            end
         end
         ST_MUL: begin
            // wrapping product becomes the radicand
            rem_in   = product[31:0];
            q_in     = 32'd0;
            bit_in   = 32'h4000_0000;
            count_in = 5'd15;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (!sub_borrow) begin
               rem_in = sub_diff[31:0];
               q_in   = (q_ff >> 1) + bit_ff;
            end else begin
               q_in   = q_ff >> 1;
            end
            bit_in   = bit_ff >> 2;
            count_in = count_ff - 5'd1;
            if (count_ff == 5'd0) begin
               // root stays in q for the divide by the window
               rem_in     = 32'd0;
               divisor_in = win_ff;
               count_in   = 5'd31;
               state_in   = ST_DIV2;
            end
         end
         ST_DONE: begin
            if (cnt_sum >= win_ff) begin
               rsp_payload_in.window_next          = win_ff + 32'd1;
               rsp_payload_in.window_fraction_next = 32'd0;
            end else begin
               rsp_payload_in.window_next          = win_ff;
               rsp_payload_in.window_fraction_next = cnt_sum;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= 5'd0;
         peak_ff      <= 32'd0;
         latest_ff    <= 32'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         peak_ff      <= peak_in;
         latest_ff    <= latest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff         <= win_in;
      cnt_ff         <= cnt_in;
      q_ff           <= q_in;
      rem_ff         <= rem_in;
      divisor_ff     <= divisor_in;
      bit_ff         <= bit_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // the output register is always free when a long item finishes
   `ASSERT_IMPLIES(a_done_slot_free, clock, reset, state_ff == ST_DONE, !rsp_valid_ff)
   // no item is taken while the sequencer is busy
   `ASSERT_IMPLIES(a_ready_only_idle, clock, reset, req_chan.ready, state_ff == ST_IDLE)
   // the root bit stays one-hot as it walks down one position pair at a time
   `ASSERT_IMPLIES(a_sqrt_bit_onehot, clock, reset, state_ff == ST_SQRT, $onehot(bit_ff))
   // a long ack never ends without presenting its result
   `ASSERT_NEXT(a_done_gives_item, clock, reset, state_ff == ST_DONE, rsp_valid_ff)

endmodule

### dv/rtt_scaled_congestion_window_unit_tb.sv
// self-checking testbench for rtt_scaled_congestion_window_unit: directed table then random items
// depends on rscw_pkg, rscw_req_if, rscw_rsp_if and the unit itself
`timescale 1ns / 100ps

module rtt_scaled_congestion_window_unit_tb;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      rscw_pkg::req_type item;
      bit                exact;
      rscw_pkg::rsp_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   rscw_req_if req_chan ();
   rscw_rsp_if rsp_chan ();

   rtt_scaled_congestion_window_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predictor state
   logic [31:0] rtt_peak_q;
   logic [31:0] rtt_latest_q;

   rscw_pkg::rsp_type expected_windows[$];
   stim_row_type      directed_rows[$];
   int      mismatches = 0;
   bit      steady = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [31:0] floor_sqrt(input logic [31:0] v);
      logic [15:0] root;
      logic [15:0] trial;
      root = '0;
      for (int b = 15; b >= 0; b--) begin
         trial = root | (16'd1 << b);
         if ({16'd0, trial} * {16'd0, trial} <= v) root = trial;
      end
      return {16'd0, root};
   endfunction

   // window update for one accepted item; also moves the rtt state on
   function automatic rscw_pkg::rsp_type advance_window(input rscw_pkg::req_type it);
      rscw_pkg::rsp_type res;
      logic [31:0] win;
      logic [31:0] frac;
      logic [31:0] sample_plus;
      logic [31:0] divisor;
      logic [31:0] product;
      logic [31:0] step;
      logic [32:0] total;
      win  = it.window_now;
      frac = it.window_fraction_now;
      case (it.mode)
         rscw_pkg::MODE_RTT: begin
            sample_plus = (it.rtt_sample_us == 32'hFFFF_FFFF) ? it.rtt_sample_us
                                                              : it.rtt_sample_us + 32'd1;
            rtt_latest_q = sample_plus;
            if (sample_plus > rtt_peak_q || rtt_peak_q == 32'd0) rtt_peak_q = sample_plus;
         end
         rscw_pkg::MODE_LOSS: begin
            rtt_peak_q = '0;
         end
         rscw_pkg::MODE_ACK: begin
            if (it.window_limited) begin
               if (win < it.slow_start_limit) begin
                  total = {1'b0, win} + {17'd0, it.acked_count};
                  win = (total < {1'b0, it.slow_start_limit}) ? total[31:0]
                                                              : it.slow_start_limit;
               end else begin
                  divisor = (rtt_latest_q == 32'd0) ? 32'd1 : rtt_latest_q;
                  product = (rtt_peak_q / divisor) * win;
                  step = (win == 32'd0) ? 32'd0 : floor_sqrt(product) / win;
                  frac = frac + step;
                  if (frac >= win) begin
                     frac = '0;
                     win = win + 32'd1;
                  end
               end
            end
         end
         default: ;
      endcase
      res.window_next = win;
      res.window_fraction_next = frac;
      return res;
   endfunction

   function automatic void add_row(input logic [1:0] mode, input logic lim,
                                   input logic [15:0] acked, input logic [31:0] rtt,
                                   input logic [31:0] win, input logic [31:0] frac,
                                   input logic [31:0] thresh, input bit exact,
                                   input logic [31:0] want_win, input logic [31:0] want_frac);
      stim_row_type row;
      row.item = '{mode, lim, acked, rtt, win, frac, thresh};
      row.exact = exact;
      row.want = '{want_win, want_frac};
      directed_rows.push_back(row);
   endfunction

   function automatic rscw_pkg::req_type random_item();
      rscw_pkg::req_type it;
      int unsigned       pick;
      it = '{2'($urandom_range(3)), 1'($urandom_range(1)), 16'($urandom_range(65535)),
             $urandom, $urandom, $urandom, $urandom};
      pick = $urandom_range(99);
      if (pick < 30) begin
         it.mode = rscw_pkg::MODE_RTT;
         pick = $urandom_range(99);
         if (pick < 60) it.rtt_sample_us = $urandom_range(200);
         else if (pick < 85) it.rtt_sample_us = $urandom_range(100000);
      end else if (pick < 35) begin
         it.mode = rscw_pkg::MODE_LOSS;
      end else if (pick < 37) begin
         it.mode = MODE_UNUSED;
      end else begin
         it.mode = rscw_pkg::MODE_ACK;
         it.window_limited = ($urandom_range(99) < 90);
         pick = $urandom_range(99);
         if (pick < 50) it.window_now = $urandom_range(64, 1);
         else if (pick < 70) it.window_now = $urandom_range(1 << 20, 1);
         else if (pick < 75) it.window_now = '0;
         else if (pick < 80) it.window_now = 32'hFFFF_FFFF - $urandom_range(3);
         // mostly congestion avoidance, the rest slow start with a random threshold
         if ($urandom_range(99) < 60) it.slow_start_limit = $urandom_range(it.window_now);
         if ($urandom_range(99) < 50) it.window_fraction_now = it.window_now - $urandom_range(3);
         if ($urandom_range(99) < 50) it.acked_count = 16'($urandom_range(100));
      end
      return it;
   endfunction

   // send one item and record its expectation at acceptance
   task automatic put_item(input rscw_pkg::req_type it, input bit exact,
                           input rscw_pkg::rsp_type want);
      rscw_pkg::rsp_type predicted;
      while (!steady && $urandom_range(99) < 8) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= it;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predicted = advance_window(it);
      expected_windows.push_back(exact ? want : predicted);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_windows.size() != 0);
   endtask

   // result side: random stalls and the field checks
   always @(posedge clock) begin
      rscw_pkg::rsp_type got;
      rscw_pkg::rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (expected_windows.size() == 0) begin
            $error("unexpected result item window_next %h window_fraction_next %h",
                   got.window_next, got.window_fraction_next);
            mismatches++;
         end else begin
            want = expected_windows.pop_front();
            if (got.window_next !== want.window_next) begin
               $error("window_next expected %h actual %h", want.window_next, got.window_next);
               mismatches++;
            end
            if (got.window_fraction_next !== want.window_fraction_next) begin
               $error("window_fraction_next expected %h actual %h",
                      want.window_fraction_next, got.window_fraction_next);
               mismatches++;
            end
         end
      end
      rsp_chan.ready <= steady ? 1'b1 : ($urandom_range(99) >= 8);
   end

   initial begin
      int                counted;
      rscw_pkg::req_type it;
      rscw_pkg::rsp_type none;
      none = '0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      rtt_peak_q = '0;
      rtt_latest_q = 32'd1;

      // idle state, limit values, echoes and the rtt edge cases
      add_row(rscw_pkg::MODE_ACK, 1, 16'd0, 32'd0, 32'd10, 32'd3, 32'd5, 1, 32'd10, 32'd3);
      add_row(rscw_pkg::MODE_ACK, 0, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1,
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_row(MODE_UNUSED, 1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_row(rscw_pkg::MODE_RTT, 0, 16'd0, 32'hFFFF_FFFE, 32'd1, 32'd0, 32'd0, 1, 32'd1, 32'd0);
      add_row(rscw_pkg::MODE_RTT, 1, 16'd5, 32'hFFFF_FFFF, 32'd2, 32'd8, 32'd9, 1, 32'd2, 32'd8);
      add_row(rscw_pkg::MODE_ACK, 1, 16'hFFFF, 32'd0, 32'hFFFF_FFF0, 32'd7, 32'hFFFF_FFFF, 1,
              32'hFFFF_FFFF, 32'd7);
      add_row(rscw_pkg::MODE_ACK, 1, 16'd0, 32'd0, 32'd1, 32'd5, 32'd2, 1, 32'd1, 32'd5);
      add_row(rscw_pkg::MODE_ACK, 1, 16'd1, 32'd0, 32'd3, 32'd6, 32'd10, 1, 32'd4, 32'd6);
      // zero window outside slow start, then window wrap past the top
      add_row(rscw_pkg::MODE_ACK, 1, 16'd0, 32'd0, 32'd0, 32'd12345, 32'd0, 1, 32'd1, 32'd0);
      add_row(rscw_pkg::MODE_ACK, 1, 16'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1,
              32'd0, 32'd0);
      add_row(rscw_pkg::MODE_LOSS, 1, 16'd3, 32'd4, 32'd77, 32'd9, 32'd1, 1, 32'd77, 32'd9);
      add_row(rscw_pkg::MODE_RTT, 0, 16'd0, 32'd99, 32'd5, 32'd6, 32'd0, 1, 32'd5, 32'd6);
      add_row(rscw_pkg::MODE_RTT, 0, 16'd0, 32'd9, 32'd5, 32'd6, 32'd0, 1, 32'd5, 32'd6);
      add_row(rscw_pkg::MODE_ACK, 1, 16'd0, 32'd0, 32'd100, 32'd0, 32'd50, 0, '0, '0);
      add_row(rscw_pkg::MODE_ACK, 1, 16'd0, 32'd0, 32'd4, 32'hFFFF_FFFF, 32'd0, 0, '0, '0);
      add_row(rscw_pkg::MODE_RTT, 0, 16'd0, 32'd0, 32'd3, 32'd1, 32'd0, 1, 32'd3, 32'd1);
      add_row(rscw_pkg::MODE_ACK, 1, 16'd0, 32'd0, 32'd1, 32'd0, 32'd1, 0, '0, '0);
      add_row(rscw_pkg::MODE_ACK, 1, 16'd0, 32'd0, 32'd7, 32'd5, 32'd3, 0, '0, '0);
      add_row(rscw_pkg::MODE_LOSS, 0, 16'd0, 32'd0, 32'd8, 32'd2, 32'd0, 1, 32'd8, 32'd2);
      add_row(rscw_pkg::MODE_RTT, 0, 16'd0, 32'd4, 32'd8, 32'd2, 32'd0, 1, 32'd8, 32'd2);
      add_row(rscw_pkg::MODE_ACK, 1, 16'd0, 32'd0, 32'd2, 32'd1, 32'd0, 0, '0, '0);
      add_row(rscw_pkg::MODE_ACK, 1, 16'd0, 32'd0, 32'd0, 32'd4, 32'd1, 1, 32'd0, 32'd4);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         put_item(directed_rows[i].item, directed_rows[i].exact, directed_rows[i].want);
      drain_results();

      counted = 0;
      while (counted < 1528) begin
         if (counted == 500) drain_results();
         steady = (counted >= 700 && counted < 1000);
         it = random_item();
         put_item(it, 1'b0, none);
         counted++;
      end
      steady = 1'b0;

      drain_results();
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/rscw_pkg.sv
src/rscw_req_if.sv
src/rscw_rsp_if.sv
src/rtt_scaled_congestion_window_unit.sv
dv/rtt_scaled_congestion_window_unit_tb.sv
